FILE: rtl/lcwa_pkg.sv
package lcwa_pkg;

  // Widths fixed by the item and register formats
  localparam int SAMPLE_WIDTH_DEF = 12;
  localparam int COUNT_W          = 8;
  localparam int OFFSET_W         = 32;
  localparam int GAIN_W           = 24;
  localparam int CFG_W            = 32;
  localparam int CFG_IDX_W        = 2;
  localparam int FRAC_BITS        = 16;
  localparam int PROD_SHIFT       = 32;
  localparam int WEIGHT_W         = 14;
  localparam int DIGIT_W          = 6;
  localparam int OUT_W            = 40;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 2'd2;

  // Register values after reset
  localparam logic [COUNT_W-1:0]  AVERAGE_COUNT_RST = 8'd100;
  localparam logic [OFFSET_W-1:0] ZERO_OFFSET_RST   = 32'd668160;
  localparam logic [GAIN_W-1:0]   GAIN_RST          = 24'd1171961;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 14'd9999;
  localparam logic [DIGIT_W-1:0]  ASCII_ZERO = 6'h30;

  // Status of the shared serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/lcwa_div.sv
// Restoring divider, one quotient bit per cycle
module lcwa_div import lcwa_pkg::*; #(
  parameter int DIVIDEND_W = SAMPLE_WIDTH_DEF + FRAC_BITS,
  parameter int DIVISOR_W  = SAMPLE_WIDTH_DEF + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output div_stat_t             stat
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  divs;
  logic [DIVIDEND_W-1:0] quo;
  logic [CNT_W-1:0]      cnt;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_sub;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_next;
  logic [DIVIDEND_W-1:0] quo_next;

  // Bring down one dividend bit and try the subtraction
  always_comb begin
    trial     = {rem, quo[DIVIDEND_W-1]};
    trial_sub = trial - {1'b0, divs};
    fits      = (trial >= {1'b0, divs});
    rem_next  = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    quo_next  = {quo[DIVIDEND_W-2:0], fits};
  end

  // Count the steps and flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      if (start) begin
        stat.busy <= 1'b1;
        stat.done <= 1'b0;
        cnt       <= CNT_W'(DIVIDEND_W);
      end else if (stat.busy) begin
        cnt       <= cnt - 1'b1;
        stat.done <= (cnt == CNT_W'(1));
        if (cnt == CNT_W'(1)) stat.busy <= 1'b0;
      end else begin
        stat.done <= 1'b0;
      end
    end
  end

  // Shift the partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      divs <= divisor;
    end else if (stat.busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

FILE: rtl/load_cell_weight_averager.sv
// Load cell weight averager.
// Input channel s_*: one item is a triple of ADC samples, one per load sensor.
// Output channel m_*: one weight item per completed window of average_count
// triples, as the weight in tenths and its four ASCII digits.
// Configuration: cfg_we/cfg_index/cfg_data write average_count (0),
// zero_offset (1) and gain (2); write only while the block is idle.
// An item that does not close a window leaves s_tready high. An item that
// closes a window starts the conversion and s_tready stays low until the
// result sits in the output register. The conversion runs six serial
// divisions of SAMPLE_WIDTH+16 steps each through one shared divider, then a
// 24-step shift-add multiply and a 14-step binary to BCD conversion.
// The result waits in the output register; while the receiver stalls, new
// triples are still accepted and summed, and a further finished weight waits
// for the register to free up.
// Reset clears the sums, the triple count and the output valid, and loads the
// registers with their default values.
module load_cell_weight_averager import lcwa_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: sample_a, sample_b, sample_c (from bit 0 up), zero padded
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  // m_tdata: weight_tenths, digit_hundreds, digit_tens, digit_units,
  // digit_tenths (from bit 0 up), zero padded
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [OUT_W-1:0]              m_tdata,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  localparam int SUM_W  = SAMPLE_WIDTH + COUNT_W;
  localparam int DIV_W  = SAMPLE_WIDTH + FRAC_BITS;
  localparam int DVS_W  = SAMPLE_WIDTH + 1;
  localparam int TOT_W  = SAMPLE_WIDTH + FRAC_BITS + 2;
  localparam int CMP_W  = (TOT_W > OFFSET_W) ? TOT_W : OFFSET_W;
  localparam int PROD_W = TOT_W + GAIN_W;
  localparam int HI_W   = PROD_W - PROD_SHIFT;
  localparam int STEP_W = $clog2(GAIN_W);
  localparam int PAD_W  = OUT_W - WEIGHT_W - 4*DIGIT_W;
  localparam int BCD_W  = 16;
  localparam logic [DVS_W-1:0] FULL_SCALE = DVS_W'(1) << SAMPLE_WIDTH;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_AVG_GO    = 10'b0000000010,
    S_AVG_WAIT  = 10'b0000000100,
    S_COND_GO   = 10'b0000001000,
    S_COND_WAIT = 10'b0000010000,
    S_OFFS      = 10'b0000100000,
    S_MUL       = 10'b0001000000,
    S_SAT       = 10'b0010000000,
    S_BCD       = 10'b0100000000,
    S_OUT       = 10'b1000000000
  } state_t;

  state_t state;

  logic [COUNT_W-1:0]  average_count;
  logic [OFFSET_W-1:0] zero_offset;
  logic [GAIN_W-1:0]   gain;

  logic [SUM_W-1:0]    sum [3];
  logic [COUNT_W-1:0]  count;
  logic [1:0]          ch;
  logic [STEP_W-1:0]   step;

  logic [SAMPLE_WIDTH-1:0] avg;
  logic [TOT_W-1:0]        total;
  logic [TOT_W-1:0]        diff;
  logic [PROD_W-1:0]       prod;
  logic [WEIGHT_W-1:0]     weight;
  logic [WEIGHT_W-1:0]     bin;
  logic [BCD_W-1:0]        bcd;

  logic [COUNT_W-1:0]  target;
  logic [COUNT_W-1:0]  n;
  logic                window_done;
  logic [SUM_W-1:0]    sum_next [3];
  logic                out_load;

  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [DVS_W-1:0]    div_divisor;
  logic [DIV_W-1:0]    div_quo;
  div_stat_t           div_stat;

  logic [TOT_W:0]      prod_sum;
  logic [PROD_W-1:0]   prod_next;
  logic [HI_W-1:0]     prod_hi;
  logic [WEIGHT_W-1:0] weight_sat;
  logic [BCD_W-1:0]    bcd_adj;
  logic [CMP_W-1:0]    total_ext;
  logic [CMP_W-1:0]    offset_ext;
  logic [CMP_W-1:0]    diff_ext;

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // Add the new triple and check for the end of the window
  always_comb begin
    target = (average_count == '0) ? COUNT_W'(1) : average_count;
    n      = count + 1'b1;
    window_done = (n >= target);
    for (int i = 0; i < 3; i++) begin
      sum_next[i] = sum[i] + SUM_W'(s_tdata[i*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
    end
  end

  // Feed the shared divider: average first, then conductance
  always_comb begin
    div_start    = (state == S_AVG_GO) || (state == S_COND_GO);
    div_dividend = DIV_W'(sum[ch]);
    div_divisor  = DVS_W'(count);
    if (state == S_COND_GO) begin
      div_dividend = {avg, FRAC_BITS'(0)};
      div_divisor  = FULL_SCALE - DVS_W'(avg);
    end
  end

  lcwa_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // Offset removal, shift-add multiply step, saturation and BCD adjust
  always_comb begin
    logic [3:0] nib;
    total_ext  = CMP_W'(total);
    offset_ext = CMP_W'(zero_offset);
    diff_ext   = total_ext - offset_ext;
    prod_sum   = {1'b0, prod[PROD_W-1:GAIN_W]} + (prod[0] ? {1'b0, diff} : '0);
    prod_next  = {prod_sum, prod[GAIN_W-1:1]};
    prod_hi    = prod[PROD_W-1:PROD_SHIFT];
    weight_sat = (prod_hi > HI_W'(WEIGHT_MAX)) ? WEIGHT_MAX : prod_hi[WEIGHT_W-1:0];
    for (int i = 0; i < 4; i++) begin
      nib = bcd[4*i +: 4];
      bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  // Control, sums and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      average_count <= AVERAGE_COUNT_RST;
      zero_offset   <= ZERO_OFFSET_RST;
      gain          <= GAIN_RST;
      count         <= '0;
      ch            <= '0;
      step          <= '0;
      m_tvalid      <= 1'b0;
      for (int i = 0; i < 3; i++) sum[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_AVERAGE_COUNT: average_count <= cfg_data[COUNT_W-1:0];
          CFG_ZERO_OFFSET:   zero_offset   <= cfg_data[OFFSET_W-1:0];
          CFG_GAIN:          gain          <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      // Hold the result until the receiver takes it
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            for (int i = 0; i < 3; i++) sum[i] <= sum_next[i];
            count <= n;
            if (window_done) begin
              ch    <= '0;
              state <= S_AVG_GO;
            end
          end
        end
        S_AVG_GO:  state <= S_AVG_WAIT;
        S_AVG_WAIT: begin
          if (div_stat.done) state <= S_COND_GO;
        end
        S_COND_GO: state <= S_COND_WAIT;
        S_COND_WAIT: begin
          if (div_stat.done) begin
            if (ch == 2'd2) begin
              state <= S_OFFS;
            end else begin
              ch    <= ch + 1'b1;
              state <= S_AVG_GO;
            end
          end
        end
        S_OFFS: begin
          step  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          step <= step + 1'b1;
          if (step == STEP_W'(GAIN_W - 1)) state <= S_SAT;
        end
        S_SAT: begin
          step  <= '0;
          state <= S_BCD;
        end
        S_BCD: begin
          step <= step + 1'b1;
          if (step == STEP_W'(WEIGHT_W - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            count    <= '0;
            for (int i = 0; i < 3; i++) sum[i] <= '0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: total <= '0;
      S_AVG_WAIT: begin
        if (div_stat.done) avg <= div_quo[SAMPLE_WIDTH-1:0];
      end
      S_COND_WAIT: begin
        if (div_stat.done) total <= total + TOT_W'(div_quo);
      end
      S_OFFS: begin
        prod <= {TOT_W'(0), gain};
        diff <= (total_ext > offset_ext) ? diff_ext[TOT_W-1:0] : '0;
      end
      S_MUL: prod <= prod_next;
      S_SAT: begin
        weight <= weight_sat;
        bin    <= weight_sat;
        bcd    <= '0;
      end
      S_BCD: begin
        bcd <= {bcd_adj[BCD_W-2:0], bin[WEIGHT_W-1]};
        bin <= {bin[WEIGHT_W-2:0], 1'b0};
      end
      S_OUT: begin
        if (out_load) begin
          m_tdata <= {PAD_W'(0),
                      ASCII_ZERO + DIGIT_W'(bcd[3:0]),
                      ASCII_ZERO + DIGIT_W'(bcd[7:4]),
                      ASCII_ZERO + DIGIT_W'(bcd[11:8]),
                      ASCII_ZERO + DIGIT_W'(bcd[15:12]),
                      weight};
        end
      end
      default: ;
    endcase
  end

  // A fresh result leaves the window cleared
  a_clear_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (count == '0) && (sum[0] == '0))
    else $error("window not cleared after result");

  // Divider completes only while a wait state expects it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_AVG_WAIT) || (state == S_COND_WAIT))
    else $error("divider done outside a wait state");

  // No input is taken while the divider runs
  a_div_idle_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_stat.busy)
    else $error("input ready while divider busy");

  // Weight on the output never exceeds saturation
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[WEIGHT_W-1:0] <= WEIGHT_MAX))
    else $error("weight above saturation");

endmodule

FILE: sim/load_cell_weight_averager_test.sv
module load_cell_weight_averager_test;
  import lcwa_pkg::*;

  localparam int          SW            = SAMPLE_WIDTH_DEF;
  localparam int          S_TDATA_W     = ((3*SW+7)/8)*8;
  localparam logic [63:0] FULL_SCALE    = 64'd1 << SW;
  localparam int          SAMPLE_MAX    = (1 << SW) - 1;
  localparam int          RESET_CYCLES  = 11;
  localparam int          SETTLE_CYCLES = 240;
  localparam int          RX_HOLD_CYCLES = 600;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          RANDOM_PHASES  = 12;
  // Index past the three registers, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [SW-1:0] sample_c;
    logic [SW-1:0] sample_b;
    logic [SW-1:0] sample_a;
  } triple_t;

  typedef struct packed {
    logic [DIGIT_W-1:0]  digit_tenths;
    logic [DIGIT_W-1:0]  digit_units;
    logic [DIGIT_W-1:0]  digit_tens;
    logic [DIGIT_W-1:0]  digit_hundreds;
    logic [WEIGHT_W-1:0] weight_tenths;
  } weight_item_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  // s_tdata: sample_a, sample_b, sample_c (from bit 0 up), zero padded
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  // m_tdata: weight_tenths, digit_hundreds, digit_tens, digit_units, digit_tenths
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  // Register copies and window state of the predictor
  logic [COUNT_W-1:0]  avg_count  = AVERAGE_COUNT_RST;
  logic [OFFSET_W-1:0] offset_q16 = ZERO_OFFSET_RST;
  logic [GAIN_W-1:0]   gain_q16   = GAIN_RST;
  logic [19:0]         acc_a = '0, acc_b = '0, acc_c = '0;
  logic [COUNT_W-1:0]  tally = '0;

  triple_t      triples_to_send[$];
  weight_item_t weights_due[$];
  int           triples_queued = 0;
  int           triples_taken  = 0;
  int           fail_count     = 0;
  int           idle_cycles    = 0;
  int           hold_left      = 0;
  logic         stall_kick     = 1'b0;
  logic         tx_steady      = 1'b0;
  logic         rx_steady      = 1'b0;

  load_cell_weight_averager dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Conductance of one channel in Q16 microsiemens from its window sum
  function automatic logic [63:0] siemens_q16(input logic [19:0] total,
                                              input logic [COUNT_W:0] n);
    logic [63:0] avg;
    avg = 64'(total) / 64'(n);
    if (avg == 0) return 64'd0;
    return (avg << FRAC_BITS) / (FULL_SCALE - avg);
  endfunction

  // Add one triple into the window; close it and queue the weight when full
  function automatic void absorb_triple(input triple_t t);
    logic [COUNT_W:0]   n;
    logic [COUNT_W:0]   target;
    logic [63:0]        total;
    logic [63:0]        scaled;
    int                 w;
    weight_item_t       r;
    acc_a  = acc_a + 20'(t.sample_a);
    acc_b  = acc_b + 20'(t.sample_b);
    acc_c  = acc_c + 20'(t.sample_c);
    n      = {1'b0, tally} + 1'b1;
    target = (avg_count == '0) ? {{COUNT_W{1'b0}}, 1'b1} : {1'b0, avg_count};
    if (n < target) begin
      tally = n[COUNT_W-1:0];
      return;
    end
    total = siemens_q16(acc_a, n) + siemens_q16(acc_b, n) + siemens_q16(acc_c, n);
    if (total > 64'(offset_q16)) begin
      scaled = ((total - 64'(offset_q16)) * 64'(gain_q16)) >> PROD_SHIFT;
      w = (scaled > 64'(WEIGHT_MAX)) ? int'(WEIGHT_MAX) : int'(scaled);
    end else begin
      w = 0;
    end
    acc_a = '0;
    acc_b = '0;
    acc_c = '0;
    tally = '0;
    r.weight_tenths  = WEIGHT_W'(w);
    r.digit_hundreds = ASCII_ZERO + DIGIT_W'((w / 1000) % 10);
    r.digit_tens     = ASCII_ZERO + DIGIT_W'((w / 100) % 10);
    r.digit_units    = ASCII_ZERO + DIGIT_W'((w / 10) % 10);
    r.digit_tenths   = ASCII_ZERO + DIGIT_W'(w % 10);
    weights_due.push_back(r);
  endfunction

  function automatic void queue_triple(input int a, input int b, input int c);
    triple_t t;
    t.sample_a = SW'(a);
    t.sample_b = SW'(b);
    t.sample_c = SW'(c);
    triples_to_send.push_back(t);
    triples_queued++;
  endfunction

  // Value near a centre level, clipped to the ADC range
  function automatic int near(input int centre);
    int v;
    v = centre + int'($urandom_range(0, 64)) - 32;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v;
  endfunction

  function automatic int rail_sample();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 1;
      2:       return SAMPLE_MAX - 1;
      default: return SAMPLE_MAX;
    endcase
  endfunction

  function automatic int pick_level();
    return ($urandom_range(0, 1) != 0) ? int'($urandom_range(3200, SAMPLE_MAX))
                                       : int'($urandom_range(0, SAMPLE_MAX));
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Write one register and mirror it in the predictor; block must be idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_AVERAGE_COUNT: avg_count  = value[COUNT_W-1:0];
      CFG_ZERO_OFFSET:   offset_q16 = value[OFFSET_W-1:0];
      CFG_GAIN:          gain_q16   = value[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Hold until every triple is taken and every weight has arrived, then let
  // any conversion still running finish
  task automatic drain();
    while (triples_taken != triples_queued || weights_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: offer queued triples, predict on each accepted item
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_triple(triple_t'(s_tdata[3*SW-1:0]));
        triples_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (triples_to_send.size() != 0 && (tx_steady || $urandom_range(0, 99) >= 10)) begin
          s_tdata  <= S_TDATA_W'(triples_to_send.pop_front());
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted weight with the oldest prediction
  always @(posedge clk) begin
    weight_item_t got;
    weight_item_t want;
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = weight_item_t'(m_tdata[$bits(weight_item_t)-1:0]);
        if (weights_due.size() == 0) begin
          $error("weight item with no prediction waiting: weight_tenths %0d",
                 got.weight_tenths);
          fail_count++;
        end else begin
          want = weights_due.pop_front();
          check_field("weight_tenths", int'(want.weight_tenths), int'(got.weight_tenths));
          check_field("digit_hundreds", int'(want.digit_hundreds),
                      int'(got.digit_hundreds));
          check_field("digit_tens", int'(want.digit_tens), int'(got.digit_tens));
          check_field("digit_units", int'(want.digit_units), int'(got.digit_units));
          check_field("digit_tenths", int'(want.digit_tenths), int'(got.digit_tenths));
        end
      end
      if (stall_kick) hold_left <= RX_HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      m_tready <= (hold_left == 0) && (rx_steady || $urandom_range(0, 99) >= 10);
    end
  end

  // Watchdog: give up after a long run of cycles with no traffic at all
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int ph;
    int k;
    int span;
    int n_items;
    int la, lb, lc;
    int pick;
    logic [COUNT_W-1:0]  count;
    logic [OFFSET_W-1:0] offset;
    logic [GAIN_W-1:0]   gain;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // One triple per weight, reset offset and gain: rails and single channels
    write_reg(CFG_AVERAGE_COUNT, CFG_W'(1));
    queue_triple(0, 0, 0);
    queue_triple(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    queue_triple(SAMPLE_MAX, 0, 0);
    queue_triple(0, SAMPLE_MAX, 0);
    queue_triple(0, 0, SAMPLE_MAX);
    queue_triple(1, 1, 1);
    queue_triple(4000, 3980, 3990);
    queue_triple(3900, 3800, 3700);
    drain();

    // No offset, full gain
    write_reg(CFG_ZERO_OFFSET, CFG_W'(0));
    write_reg(CFG_GAIN, CFG_W'(24'hFF_FFFF));
    queue_triple(2048, 2048, 2048);
    queue_triple(1, 2, 3);
    drain();

    // Offset beyond any sum, zero gain; stray index must change nothing
    write_reg(CFG_ZERO_OFFSET, 32'hFFFF_FFFF);
    write_reg(CFG_GAIN, CFG_W'(0));
    write_reg(CFG_UNUSED, 32'h0000_0005);
    queue_triple(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    drain();

    // Count of zero behaves as one
    write_reg(CFG_AVERAGE_COUNT, CFG_W'(0));
    write_reg(CFG_ZERO_OFFSET, CFG_W'(ZERO_OFFSET_RST));
    write_reg(CFG_GAIN, CFG_W'(GAIN_RST));
    queue_triple(3990, 3990, 3990);
    queue_triple(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX - 1);
    drain();

    // Count lowered mid window: the next triple closes an eleven-triple window
    write_reg(CFG_AVERAGE_COUNT, CFG_W'(20));
    for (k = 0; k < 10; k++) queue_triple(4000 + k, 3950 - k, 3900);
    drain();
    write_reg(CFG_AVERAGE_COUNT, CFG_W'(5));
    queue_triple(4010, 3940, 3890);
    drain();

    // Random phases, each with its own register settings
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       count = COUNT_W'(1);
        3:       count = COUNT_W'(255);
        5:       count = '0;
        default: count = COUNT_W'($urandom_range(1, 12));
      endcase
      offset = $urandom_range(0, 3000000);
      gain   = GAIN_W'($urandom_range(1, 24'hFF_FFFF));
      if (ph == 7) begin
        offset = 32'hFFFF_FFFF;
        gain   = '0;
      end
      if (ph == 8) begin
        offset = '0;
        gain   = 24'hFF_FFFF;
      end
      if (ph == 9) offset = $urandom();
      write_reg(CFG_AVERAGE_COUNT, CFG_W'(count));
      write_reg(CFG_ZERO_OFFSET, offset);
      write_reg(CFG_GAIN, CFG_W'(gain));
      tx_steady <= (ph == 3);
      rx_steady <= (ph == 3);

      // Mostly windows of related readings, some noise and rail values
      n_items = (count == 8'd255) ? 400 : 100;
      span    = (count == '0) ? 1 : int'(count);
      la = pick_level();
      lb = pick_level();
      lc = pick_level();
      for (k = 0; k < n_items; k++) begin
        if (k % span == 0) begin
          la = pick_level();
          lb = pick_level();
          lc = pick_level();
        end
        pick = int'($urandom_range(0, 99));
        if (pick < 75)
          queue_triple(near(la), near(lb), near(lc));
        else if (pick < 90)
          queue_triple(int'($urandom_range(0, SAMPLE_MAX)), int'($urandom_range(0, SAMPLE_MAX)),
                       int'($urandom_range(0, SAMPLE_MAX)));
        else
          queue_triple(rail_sample(), rail_sample(), rail_sample());
      end

      // Hold the receiver off long enough for the block to back up
      if (ph == 0) begin
        @(posedge clk);
        stall_kick <= 1'b1;
        @(posedge clk);
        stall_kick <= 1'b0;
      end
      drain();
    end

    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/lcwa_pkg.sv
rtl/lcwa_div.sv
rtl/load_cell_weight_averager.sv
sim/load_cell_weight_averager_test.sv
